[src/hvd_pkg.sv]
package hvd_pkg;

  localparam int F     = 30;
  localparam int DW    = F + 4;
  localparam int IW    = $clog2(F);
  localparam int AW    = 34;
  localparam int RW    = F + 1;
  localparam int MW    = F + 3;
  localparam int VW    = F + 2;
  localparam int QW    = 2 * F + 2;
  localparam int RADW  = 23;
  localparam int DISTW = 31;

  typedef logic signed [DW-1:0] sfix_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t TURN_HU    = 34'sd7200000000;
  localparam ang_t HALF_HU    = 34'sd3600000000;
  localparam ang_t QUARTER_HU = 34'sd1800000000;

  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C235;
  localparam logic [63:0] GAIN_SEED = 64'h26DD3B6A;
  localparam logic [31:0] RAD_PER_HU = 32'((PI_Q62 + 64'd1800000000) / 64'd3600000000);

  localparam sfix_t ONE = sfix_t'({{(DW-F-1){1'b0}}, 1'b1, {F{1'b0}}});
  localparam logic [DISTW-1:0] DIST_MAX = {DISTW{1'b1}};

  typedef struct packed {
    sfix_t x;
    sfix_t y;
    sfix_t z;
    logic  flip;
  } rot_t;

  typedef struct packed {
    sfix_t x;
    sfix_t y;
    sfix_t z;
  } vec_t;

  typedef struct packed {
    logic [QW-1:0] rad;
    logic [RW-1:0] root;
    logic [MW-1:0] rem;
  } sqr_t;

  typedef logic [F-1:0][DW-1:0] atan_tab_t;

  function automatic logic [63:0] round_shift(logic [63:0] v, int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  // Shift-and-subtract division, only evaluated while building constants.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    int          i;
    r = '0;
    q = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t   t;
    logic [63:0] sum;
    logic [63:0] term;
    int          i;
    int          k;
    for (i = 0; i < F; i++) begin
      sum = '0;
      if (i == 0) begin
        sum = (PI_Q60 + 64'd2) >> 2;
      end else begin
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
          term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
          sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
      t[i] = DW'(round_shift(sum, 60 - F));
    end
    return t;
  endfunction

  function automatic logic [63:0] build_gain();
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    int          i;
    int          k;
    p = 64'd1 << 60;
    y = GAIN_SEED << 30;
    for (i = 0; i < F; i++) begin
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    for (k = 0; k < 5; k++) begin
      t = mul_shift(y, y, 60);
      t = mul_shift(p, t, 60);
      y = mul_shift(y, (64'd3 << 60) - t, 61);
    end
    return round_shift(y, 60 - F);
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();
  localparam sfix_t     GAIN     = sfix_t'(DW'(build_gain()));

  // Product of two fixed-point values, magnitude rounded half up.
  function automatic sfix_t qmul(sfix_t a, sfix_t b);
    logic [DW-1:0]   ma;
    logic [DW-1:0]   mb;
    logic [2*DW-1:0] p;
    sfix_t           r;
    ma = a[DW-1] ? DW'(-a) : DW'(a);
    mb = b[DW-1] ? DW'(-b) : DW'(b);
    p  = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
    p  = p + ((2*DW)'(1) << (F - 1));
    r  = sfix_t'(DW'(p >> F));
    return (a[DW-1] != b[DW-1]) ? -r : r;
  endfunction

endpackage

[src/haversine_distance.sv]
// Throughput: one point pair per cycle; busy_o stays low, the datapath is
// a fixed pipeline of CORDIC rotation, square root and vectoring cells.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset (rst_ni, async, active low) empties the pipeline and sets the
// earth radius register to 6371000 m.
module haversine_distance import hvd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [30:0]       lat_a_i,
  input  logic signed [31:0]       lon_a_i,
  input  logic signed [30:0]       lat_b_i,
  input  logic signed [31:0]       lon_b_i,
  output logic                     done_o,
  output logic [DISTW-1:0]         distance_cm_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [RADW-1:0]          cfg_data_i
);

  localparam int LAT    = 3 * F + 12;
  localparam int V_M3   = F + 8;
  localparam int V_SQRT = 2 * F + 9;

  logic            acc;
  logic [LAT-1:0]  vld_q;
  logic [RADW-1:0] radius_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= RADW'(6371000);
    end else begin
      vld_q <= {vld_q[LAT-2:0], acc};
      if (cfg_valid_i && cfg_ready_o) radius_q <= cfg_data_i;
    end
  end

  // Angle preparation: four lanes (half lat difference, half lon difference,
  // both latitudes), reduced into one turn and folded into +-90 degrees.
  ang_t        u_q  [4];
  ang_t        r1_q [4];
  ang_t        r2_q [4];
  ang_t        r3_q [4];
  logic        f3_q [4];
  logic [63:0] p4_q [4];
  logic        n4_q [4];
  logic        f4_q [4];
  rot_t        rc   [4][F+1];
  rot_t        s5_q [4];

  always_ff @(posedge clk_i) begin
    u_q[0] <= AW'(lat_b_i) - AW'(lat_a_i);
    u_q[1] <= AW'(lon_b_i) - AW'(lon_a_i);
    u_q[2] <= AW'(lat_a_i) <<< 1;
    u_q[3] <= AW'(lat_b_i) <<< 1;
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [AW-1:0] mag;
    logic [63:0]   zr;
    sfix_t         zs;

    always_ff @(posedge clk_i) begin
      if (u_q[l] >= TURN_HU)       r1_q[l] <= u_q[l] - TURN_HU;
      else if (u_q[l] <= -TURN_HU) r1_q[l] <= u_q[l] + TURN_HU;
      else                         r1_q[l] <= u_q[l];

      if (r1_q[l] >= HALF_HU)      r2_q[l] <= r1_q[l] - TURN_HU;
      else if (r1_q[l] < -HALF_HU) r2_q[l] <= r1_q[l] + TURN_HU;
      else                         r2_q[l] <= r1_q[l];

      if (r2_q[l] > QUARTER_HU) begin
        r3_q[l] <= HALF_HU - r2_q[l];
        f3_q[l] <= 1'b1;
      end else if (r2_q[l] < -QUARTER_HU) begin
        r3_q[l] <= -HALF_HU - r2_q[l];
        f3_q[l] <= 1'b1;
      end else begin
        r3_q[l] <= r2_q[l];
        f3_q[l] <= 1'b0;
      end

      p4_q[l] <= {32'd0, mag[31:0]} * {32'd0, RAD_PER_HU};
      n4_q[l] <= r3_q[l][AW-1];
      f4_q[l] <= f3_q[l];

      s5_q[l].x    <= GAIN;
      s5_q[l].y    <= '0;
      s5_q[l].z    <= n4_q[l] ? -zs : zs;
      s5_q[l].flip <= f4_q[l];
    end

    always_comb begin
      mag = r3_q[l][AW-1] ? AW'(-r3_q[l]) : AW'(r3_q[l]);
      zr  = (p4_q[l] + (64'd1 << (61 - F))) >> (62 - F);
      zs  = sfix_t'(zr[DW-1:0]);
    end

    assign rc[l][0] = s5_q[l];

    for (genvar i = 0; i < F; i++) begin : g_cell
      hvd_rot_cell u_rot (
        .clk_i (clk_i),
        .idx_i (IW'(i)),
        .d_i   (rc[l][i]),
        .d_o   (rc[l][i+1])
      );
    end
  end

  // v = sin^2(dlat/2) + cos(lat_a) cos(lat_b) sin^2(dlon/2)
  sfix_t            ca, cb;
  sfix_t            plat_q, pcc_q, plon_q, plat2_q, p2_q;
  logic signed [DW:0] vs;
  logic [VW-1:0]    v_q, w_q;

  assign ca = rc[2][F].flip ? -rc[2][F].x : rc[2][F].x;
  assign cb = rc[3][F].flip ? -rc[3][F].x : rc[3][F].x;
  assign vs = (DW+1)'(plat2_q) + (DW+1)'(p2_q);

  always_ff @(posedge clk_i) begin
    plat_q  <= qmul(rc[0][F].y, rc[0][F].y);
    pcc_q   <= qmul(ca, cb);
    plon_q  <= qmul(rc[1][F].y, rc[1][F].y);
    plat2_q <= plat_q;
    p2_q    <= qmul(pcc_q, plon_q);
    if (vs[DW]) begin
      v_q <= '0;
      w_q <= VW'(ONE);
    end else if (vs > (DW+1)'(ONE)) begin
      v_q <= VW'(ONE);
      w_q <= '0;
    end else begin
      v_q <= VW'(vs);
      w_q <= VW'(ONE) - VW'(vs);
    end
  end

  // Square roots of v and 1-v, one result bit per cell.
  sqr_t sa [F+2];
  sqr_t sb [F+2];

  assign sa[0] = '{rad: {v_q, {F{1'b0}}}, root: '0, rem: '0};
  assign sb[0] = '{rad: {w_q, {F{1'b0}}}, root: '0, rem: '0};

  for (genvar p = 0; p <= F; p++) begin : g_sqrt
    hvd_sqrt_cell u_sqa (.clk_i(clk_i), .d_i(sa[p]), .d_o(sa[p+1]));
    hvd_sqrt_cell u_sqb (.clk_i(clk_i), .d_i(sb[p]), .d_o(sb[p+1]));
  end

  // Central half angle by atan2(sqrt(v), sqrt(1-v)).
  vec_t vc [F+1];

  assign vc[0].x = sfix_t'(DW'(sb[F+1].root));
  assign vc[0].y = sfix_t'(DW'(sa[F+1].root));
  assign vc[0].z = '0;

  for (genvar i = 0; i < F; i++) begin : g_vec
    hvd_vec_cell u_vec (
      .clk_i (clk_i),
      .idx_i (IW'(i)),
      .d_i   (vc[i]),
      .d_o   (vc[i+1])
    );
  end

  // Scale by twice the radius in centimeters and saturate.
  logic [DW-1:0]    zc;
  logic [29:0]      r100;
  logic [63:0]      prod_q;
  logic [64:0]      dr;
  logic [DISTW-1:0] dist_q;

  assign zc   = vc[F].z[DW-1] ? '0 : DW'(vc[F].z);
  assign r100 = 30'(radius_q) * 30'd100;
  assign dr   = (65'(prod_q) + (65'd1 << (F - 1))) >> F;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(r100) * 64'({zc[DW-2:0], 1'b0});
    dist_q <= (dr > 65'(DIST_MAX)) ? DIST_MAX : dr[DISTW-1:0];
  end

  assign done_o        = vld_q[LAT-1];
  assign distance_cm_o = dist_q;

`ifndef SYNTHESIS
  a_v_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_M3] |-> (v_q <= VW'(ONE)) && (w_q == VW'(ONE) - v_q))
    else $error("v left the unit interval");

  a_root_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[V_SQRT] |-> (RW'(sa[F+1].root) <= RW'(ONE)) && (RW'(sb[F+1].root) <= RW'(ONE)))
    else $error("square root above one");

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LAT-2] |=> done_o)
    else $error("result strobe lost");
`endif

endmodule

[src/hvd_rot_cell.sv]
module hvd_rot_cell import hvd_pkg::*; (
  input  logic          clk_i,
  input  logic [IW-1:0] idx_i,
  input  rot_t          d_i,
  output rot_t          d_o
);

  rot_t  d_d, d_q;
  sfix_t dx, dy, at;

  always_comb begin
    d_d = d_i;
    dx  = d_i.y >>> idx_i;
    dy  = d_i.x >>> idx_i;
    at  = sfix_t'(ATAN_TAB[idx_i]);
    if (!d_i.z[DW-1]) begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - at;
    end else begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign d_o = d_q;

endmodule

[src/hvd_vec_cell.sv]
module hvd_vec_cell import hvd_pkg::*; (
  input  logic          clk_i,
  input  logic [IW-1:0] idx_i,
  input  vec_t          d_i,
  output vec_t          d_o
);

  vec_t  d_d, d_q;
  sfix_t dx, dy, at;

  always_comb begin
    dx = d_i.y >>> idx_i;
    dy = d_i.x >>> idx_i;
    at = sfix_t'(ATAN_TAB[idx_i]);
    if (!d_i.y[DW-1]) begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + at;
    end else begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign d_o = d_q;

endmodule

[src/hvd_sqrt_cell.sv]
module hvd_sqrt_cell import hvd_pkg::*; (
  input  logic clk_i,
  input  sqr_t d_i,
  output sqr_t d_o
);

  sqr_t          d_d, d_q;
  logic [MW-1:0] rem_n;
  logic [MW-1:0] trial;

  // One result bit per cell: bring down the next radicand pair and try it.
  always_comb begin
    rem_n   = {d_i.rem[MW-3:0], d_i.rad[QW-1:QW-2]};
    trial   = {d_i.root, 2'b01};
    d_d.rad = {d_i.rad[QW-3:0], 2'b00};
    if (rem_n >= trial) begin
      d_d.rem  = rem_n - trial;
      d_d.root = {d_i.root[RW-2:0], 1'b1};
    end else begin
      d_d.rem  = rem_n;
      d_d.root = {d_i.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign d_o = d_q;

endmodule

[tb/hvd_checker.sv]
module hvd_checker import hvd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [30:0] lat_a_i,
  input  logic signed [31:0] lon_a_i,
  input  logic signed [30:0] lat_b_i,
  input  logic signed [31:0] lon_b_i,
  input  logic               done_i,
  input  logic [DISTW-1:0]   distance_cm_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [RADW-1:0]    cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam longint Q      = 30;
  localparam longint TURN   = 64'sd7200000000;
  localparam longint HALF   = 64'sd3600000000;
  localparam longint QUART  = 64'sd1800000000;

  longint           arctan_q [Q];
  longint           cordic_gain;
  logic [63:0]      rad_scale;
  logic [RADW-1:0]  radius_m;
  logic [DISTW-1:0] distances_due [$];
  int               errors;

  assign errors_o  = errors;
  assign pending_o = distances_due.size();

  function automatic logic [63:0] prod_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] absval(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    longint r;
    r = longint'(prod_shift(absval(a), absval(b), Q));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  initial begin
    logic [63:0] p, y, t, term;
    longint      sum;
    int          i, k;
    p = 64'd1 << 60;
    y = 64'h26DD3B6A << 30;
    for (i = 0; i < Q; i++) begin
      sum = 0;
      if (i == 0) begin
        sum = longint'((64'h3243F6A8885A308D + 64'd2) >> 2);
      end else begin
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
          term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
          sum  = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
        end
      end
      arctan_q[i] = longint'((64'(sum) + (64'd1 << 29)) >> 30);
      if (2 * i < 62) p = p + (p >> (2 * i));
    end
    for (k = 0; k < 5; k++) begin
      t = prod_shift(y, y, 60);
      t = prod_shift(p, t, 60);
      y = prod_shift(y, (64'd3 << 60) - t, 61);
    end
    cordic_gain = longint'((y + (64'd1 << 29)) >> 30);
    rad_scale   = (64'hC90FDAA22168C235 + 64'd1800000000) / 64'd3600000000;
  end

  // Angle in half-units of 1e-7 degree, folded into +-90 degrees first.
  task automatic sine_cosine(input longint u, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r    = u % TURN;
    flip = 0;
    if (r >= HALF) r -= TURN;
    else if (r < -HALF) r += TURN;
    if (r > QUART) begin
      r = HALF - r;
      flip = 1;
    end else if (r < -QUART) begin
      r = -HALF - r;
      flip = 1;
    end
    z = longint'((absval(r) * rad_scale + (64'd1 << 31)) >> 32);
    if (r < 0) z = -z;
    x = cordic_gain;
    y = 0;
    for (int i = 0; i < Q; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q[i];
      end else begin
        x += dx; y -= dy; z += arctan_q[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  function automatic logic [63:0] root_q(logic [63:0] v);
    logic [63:0] root, rem, pair, trial;
    int          b1, b0;
    root = 0;
    rem  = 0;
    for (int p = Q; p >= 0; p--) begin
      b1   = 2 * p + 1;
      b0   = 2 * p;
      pair = 0;
      if (b1 >= Q) pair |= ((v >> (b1 - Q)) & 1) << 1;
      if (b0 >= Q) pair |= (v >> (b0 - Q)) & 1;
      rem   = (rem << 2) | pair;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < Q; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q[i];
      end
    end
    return z;
  endfunction

  task automatic predict_distance(input longint la, input longint loa, input longint lb,
                                  input longint lob, output logic [DISTW-1:0] dist_cm);
    longint      s_lat, s_lon, c_a, c_b, dummy, v, z, one;
    logic [63:0] ra, rb, d;
    one = 64'sd1 << Q;
    sine_cosine(lb - la, s_lat, dummy);
    sine_cosine(lob - loa, s_lon, dummy);
    sine_cosine(2 * la, dummy, c_a);
    sine_cosine(2 * lb, dummy, c_b);
    v = fix_mul(s_lat, s_lat) + fix_mul(fix_mul(c_a, c_b), fix_mul(s_lon, s_lon));
    if (v < 0) v = 0;
    if (v > one) v = one;
    ra = root_q(64'(v));
    rb = root_q(64'(one - v));
    z  = vector_angle(longint'(ra), longint'(rb));
    if (z < 0) z = 0;
    d = prod_shift(64'(radius_m) * 64'd100, 64'(z) * 64'd2, Q);
    dist_cm = (d > 64'd2147483647) ? DIST_MAX : d[DISTW-1:0];
  endtask

  task automatic report(input string what, input logic [DISTW-1:0] got,
                        input logic [DISTW-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DISTW-1:0] d;
    if (!rst_ni) begin
      radius_m = 23'd6371000;
      distances_due.delete();
      errors = 0;
    end else begin
      if (done_i) begin
        if (distances_due.size() == 0) report("unexpected distance", distance_cm_i, '0);
        else begin
          d = distances_due.pop_front();
          if (distance_cm_i !== d) report("distance_cm", distance_cm_i, d);
        end
      end
      if (start_i && !busy_i) begin
        predict_distance(lat_a_i, lon_a_i, lat_b_i, lon_b_i, d);
        distances_due.push_back(d);
      end
      if (cfg_valid_i && cfg_ready_i) radius_m = cfg_data_i;
    end
  end

endmodule

[tb/tb_haversine_distance.sv]
module tb_haversine_distance;
  import hvd_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [30:0] lat_a_i = '0;
  logic signed [31:0] lon_a_i = '0;
  logic signed [30:0] lat_b_i = '0;
  logic signed [31:0] lon_b_i = '0;
  logic               done_o;
  logic [DISTW-1:0]   distance_cm_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [RADW-1:0]    cfg_data_i = '0;
  int                 errors;
  int                 pending;
  int                 quiet_cycles;

  always #5 clk_i = ~clk_i;

  haversine_distance u_top (.*);

  hvd_checker u_chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .lat_a_i, .lon_a_i, .lat_b_i, .lon_b_i,
    .done_i(done_o), .distance_cm_i(distance_cm_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int short_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 250);
  endfunction

  // Holds start high across back-to-back transfers; lowers it only for a gap.
  task automatic send_pair(input longint la, input longint loa, input longint lb,
                           input longint lob, input int gap);
    start_i <= 1'b1;
    lat_a_i <= 31'(la);
    lon_a_i <= 32'(loa);
    lat_b_i <= 31'(lb);
    lon_b_i <= 32'(lob);
    do @(posedge clk_i); while (busy_o);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RADW-1:0] r);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic longint rnd_lat();
    return longint'($urandom_range(0, 1800000000)) - 900000000;
  endfunction

  function automatic longint rnd_lon();
    return longint'($urandom_range(0, 2000000000)) + longint'($urandom_range(0, 1600000000))
           - 1800000000;
  endfunction

  task automatic random_pair();
    longint la, loa, lb, lob;
    int     kind;
    kind = $urandom_range(0, 9);
    la  = rnd_lat();
    loa = rnd_lon();
    lb  = rnd_lat();
    lob = rnd_lon();
    if (kind == 0) begin
      // Raw bit patterns over the full input width, which can lie outside the coordinate range.
      la  = longint'(signed'(31'($urandom())));
      loa = longint'(signed'($urandom()));
      lb  = longint'(signed'(31'($urandom())));
      lob = longint'(signed'($urandom()));
    end else if (kind < 4) begin
      // Nearby points, where the small-angle end of the math matters.
      lb  = la + longint'($urandom_range(0, 20000)) - 10000;
      lob = loa + longint'($urandom_range(0, 20000)) - 10000;
    end else if (kind == 4) begin
      // Close to antipodal.
      lb  = -la + longint'($urandom_range(0, 2000)) - 1000;
      lob = (loa > 0 ? loa - 1800000000 : loa + 1800000000)
            + longint'($urandom_range(0, 2000)) - 1000;
    end
    send_pair(la, loa, lb, lob, short_gap());
  endtask

  initial begin
    logic [RADW-1:0] radii [5] = '{23'd6300000, 23'd6400000, 23'd0, 23'h7FFFFF, 23'd6371000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(0, 0, 0, 0, 0);
    send_pair(450000000, 900000000, 450000000, 900000000, 0);
    send_pair(0, 0, 0, 1800000000, 1);
    send_pair(900000000, 0, -900000000, 0, 0);
    send_pair(-900000000, -1800000000, 900000000, 1800000000, 0);
    send_pair(0, -1800000000, 0, 1800000000, 2);
    send_pair(0, 0, 1, 0, 0);
    send_pair(0, 0, 0, 1, 0);
    send_pair(900000000, 123456789, 900000000, -987654321, 0);
    send_pair(-(1 << 30), -(64'sd1 << 31), (1 << 30) - 1, (64'sd1 << 31) - 1, 3);
    send_pair((1 << 30) - 1, (64'sd1 << 31) - 1, -(1 << 30), -(64'sd1 << 31), 0);
    send_pair(-(1 << 30), 0, -(1 << 30), 0, 0);
    send_pair(515000000, -1000000, 407000000, -740000000, 0);
    send_pair(-338000000, 1512000000, 515000000, -1000000, 0);
    send_pair(0, 899999999, 0, -900000001, 0);

    for (int phase = 0; phase < 5; phase++) begin
      write_radius(radii[phase]);
      if (phase == 3) begin
        for (int n = 0; n < 40; n++) random_pair();
      end else begin
        for (int n = 0; n < 440; n++) begin
          random_pair();
          if (n == 220) drain();
        end
      end
    end

    drain();
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
